// ----- hdl/b64c_pkg.sv -----
// Shared types, constants and character mapping functions for the base64 stream codec.
package b64c_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic       DIR_DECODE = 1'b1;
    localparam logic [7:0] PAD_CHAR   = 8'h3D;
    localparam logic [7:0] BAD_SEXTET = 8'hFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } out_item_t;

    typedef logic [3:0][7:0] group_t;

    // One queued transaction burst: count_m1 + 1 results, bytes taken from data[0] up
    typedef struct packed {
        group_t     data;
        logic [1:0] count_m1;
        logic       data_ok;
        logic       last;
    } cmd_t;

    function automatic logic [7:0] enc_char(input logic [5:0] s);
        logic [7:0] sx;
        sx = {2'b00, s};
        if (s < 6'd26)      return 8'h41 + sx;
        else if (s < 6'd52) return 8'h61 + sx - 8'd26;
        else if (s < 6'd62) return 8'h30 + sx - 8'd52;
        else if (s == 6'd62) return 8'h2B;
        else                 return 8'h2F;
    endfunction

    function automatic logic [7:0] sextet_of(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)      return c - 8'd65;
        else if (c >= 8'h61 && c <= 8'h7A) return c - 8'd71;
        else if (c >= 8'h30 && c <= 8'h39) return c + 8'd4;
        else if (c == 8'h2B)               return 8'd62;
        else if (c == 8'h2F)               return 8'd63;
        else                               return BAD_SEXTET;
    endfunction

    // Four characters for three bytes; positions at or past nchar become pad
    function automatic group_t enc_group(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [2:0] nchar);
        logic [3:0][5:0] s;
        group_t          g;
        s[0] = b0[7:2];
        s[1] = {b0[1:0], b1[7:4]};
        s[2] = {b1[3:0], b2[7:6]};
        s[3] = b2[5:0];
        for (int j = 0; j < 4; j++) begin
            g[j] = (3'(j) < nchar) ? enc_char(s[j]) : PAD_CHAR;
        end
        return g;
    endfunction

    function automatic group_t dec_group(input logic [7:0] c0, input logic [7:0] c1,
                                         input logic [7:0] c2, input logic [7:0] c3);
        logic [7:0] s0, s1, s2, s3;
        group_t     g;
        s0 = sextet_of(c0);
        s1 = sextet_of(c1);
        s2 = sextet_of(c2);
        s3 = sextet_of(c3);
        g[0] = {s0[5:0], 2'b00} + {6'd0, s1[5:4]};
        g[1] = {s1[3:0], 4'd0} + {4'd0, s2[5:2]};
        g[2] = {s2[1:0], 6'd0} + s3;
        g[3] = 8'h00;
        return g;
    endfunction

endpackage

// ----- hdl/b64c_front.sv -----
// Front end: accepts input transactions, tracks the held group and builds result bursts.
module b64c_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              in_accept,
    input  b64c_pkg::in_item_t in_item,
    output logic              push,
    output b64c_pkg::cmd_t    push_cmd
);
    import b64c_pkg::*;

    logic            direction_reg;
    logic [1:0]      cnt_reg, cnt_next;
    logic            pad_reg, pad_next;
    logic [2:0][7:0] held_reg, held_next;
    logic [7:0]      c;
    logic            last;
    logic [2:0]      n;
    group_t          data;

    assign c    = in_item.in_byte;
    assign last = in_item.in_last;

    always_comb begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        n         = 3'd0;
        data      = '0;
        if (direction_reg == DIR_ENCODE) begin
            if (cnt_reg == 2'd2) begin
                data     = enc_group(held_reg[0], held_reg[1], c, 3'd4);
                n        = 3'd4;
                cnt_next = 2'd0;
            end else begin
                if (cnt_reg != 2'd3) begin
                    held_next[cnt_reg] = c;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            if (last && cnt_next != 2'd0) begin
                data = enc_group(held_next[0], (cnt_next == 2'd2) ? held_next[1] : 8'h00,
                                 8'h00, {1'b0, cnt_next} + 3'd1);
                n    = 3'd4;
            end
        end else begin
            if (!pad_reg) begin
                if (c == PAD_CHAR) begin
                    pad_next = 1'b1;
                end else if (cnt_reg == 2'd3) begin
                    data     = dec_group(held_reg[0], held_reg[1], held_reg[2], c);
                    n        = 3'd3;
                    cnt_next = 2'd0;
                end else begin
                    held_next[cnt_reg] = c;
                    cnt_next           = cnt_reg + 2'd1;
                end
            end
            if (last && cnt_next >= 2'd2) begin
                data = dec_group(held_next[0], held_next[1],
                                 (cnt_next == 2'd3) ? held_next[2] : 8'h00, 8'h00);
                n    = {1'b0, cnt_next} - 3'd1;
            end
        end
        if (last) begin
            cnt_next = 2'd0;
            pad_next = 1'b0;
        end
    end

    assign push              = in_accept && (n != 3'd0 || last);
    assign push_cmd.data     = data;
    assign push_cmd.count_m1 = (n == 3'd0) ? 2'd0 : 2'(n - 3'd1);
    assign push_cmd.data_ok  = (n != 3'd0);
    assign push_cmd.last     = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_ENCODE;
            cnt_reg       <= 2'd0;
            pad_reg       <= 1'b0;
        end else if (cfg_valid) begin
            direction_reg <= cfg_data;
            cnt_reg       <= 2'd0;
            pad_reg       <= 1'b0;
        end else if (in_accept) begin
            cnt_reg <= cnt_next;
            pad_reg <= pad_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- hdl/b64c_fifo.sv -----
// Short command queue between front and back ends.
module b64c_fifo #(
    parameter int DEPTH = b64c_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  b64c_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output b64c_pkg::cmd_t head
);
    import b64c_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/b64c_back.sv -----
// Back end: serialises queued bursts into result transactions through an output register.
module b64c_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                empty,
    input  b64c_pkg::cmd_t      head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output b64c_pkg::out_item_t m_data
);
    import b64c_pkg::*;

    logic       m_valid_reg;
    out_item_t  m_data_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       at_end;

    assign load    = !empty && (!m_valid_reg || m_ready);
    assign at_end  = (idx_reg == head.count_m1);
    assign pop     = load && at_end;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= at_end ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.out_byte  <= head.data_ok ? head.data[idx_reg] : 8'h00;
            m_data_reg.out_valid <= head.data_ok;
            m_data_reg.out_last  <= head.last && at_end;
        end
    end

endmodule

// ----- hdl/base64_stream_codec.sv -----
// Top level of the streaming base64 encoder and decoder.
//
//  channel  role     handshake           payload
//  s_       input    s_valid/s_ready     in_item_t  {in_byte, in_last}
//  m_       result   m_valid/m_ready     out_item_t {out_byte, out_valid, out_last}
//  cfg_     config   cfg_valid/cfg_ready direction (1 bit)
//
// One input transaction is taken per cycle while the command queue has room.
// Each input gives 0 to 4 results, sent by the back end one per cycle while
// m_ready is high, so the result port sets the rate: encoding gives 4 results
// per 3 bytes. Results cross the queue, then the output register. Reset clears
// direction to encode. A stalled m_ready fills the queue, then s_ready drops.
module base64_stream_codec #(
    parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  b64c_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output b64c_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import b64c_pkg::*;

    logic in_accept;
    logic push, pop, full, empty;
    cmd_t push_cmd, head;

    assign s_ready   = !full;
    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && !full;

    b64c_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_item   (s_data),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    b64c_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    b64c_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .empty   (empty),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- hdl/b64c_checker.sv -----
// Port-level assertions for the base64 stream codec, bound to the top level.
module b64c_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input b64c_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input b64c_pkg::out_item_t m_data,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic                cfg_data
);
    import b64c_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.out_valid |-> m_data.out_last && m_data.out_byte == 8'h00)
        else $error("empty result without end mark");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind base64_stream_codec b64c_checker u_b64c_checker (.*);
